// ===== hdl/alli_pkg.sv =====
// Shared types and codes for the array-backed linked list block.
`timescale 1ns / 1ps
`default_nettype none

package alli_pkg;

    // Request kinds carried on the input tuser
    localparam logic [1:0] OP_APPEND  = 2'd0;
    localparam logic [1:0] OP_PREPEND = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    // Result status carried on the output tuser
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LINK,
        S_WALK_RD,
        S_WALK_EMIT
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/alli_slots.sv =====
// Slot storage: data and next-link memories, one write port each, one registered read.
`timescale 1ns / 1ps
`default_nettype none

module alli_slots #(
    parameter int CAPACITY = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_data_we,
    input  wire logic [$clog2(CAPACITY)-1:0]        i_data_addr,
    input  wire logic [31:0]                        i_data_wdata,
    input  wire logic                               i_next_we,
    input  wire logic [$clog2(CAPACITY)-1:0]        i_next_addr,
    input  wire logic [$clog2(CAPACITY+1)-1:0]      i_next_wdata,
    input  wire logic [$clog2(CAPACITY)-1:0]        i_rd_addr,
    output logic      [31:0]                        o_rd_data,
    output logic      [$clog2(CAPACITY+1)-1:0]      o_rd_next
);

    localparam int LW = $clog2(CAPACITY + 1);

    logic [31:0]   r_data_mem [CAPACITY];
    logic [LW-1:0] r_next_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_data_we) begin
            r_data_mem[i_data_addr] <= i_data_wdata;
        end
        o_rd_data <= r_data_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_next_we) begin
            r_next_mem[i_next_addr] <= i_next_wdata;
        end
        o_rd_next <= r_next_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== hdl/array_linked_list_insert_top.sv =====
// Top level of the array-backed linked list: request decode, slot allocation, list walk.
// Insert: result registered in the cycle after accept; prepend and empty-list insert leave
//   the block idle, append passes through S_LINK (tail link, then new slot's null link).
// Read-out: per element, one registered read of the slot memories, then emit when the
//   output is free; up to CAPACITY elements. Empty list: one result the cycle after accept.
// Reset (i_rst_n low, synchronous): used flags cleared, head/tail set to null, output
//   register emptied. Slot memories are not cleared; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module array_linked_list_insert_top
    import alli_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request side
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] new_value
    input  wire logic [1:0]  s_tuser,   // [1:0] opcode
    // result side
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [31:0] out_value
    output logic      [1:0]  m_tuser,   // [1:0] status
    output logic             m_tlast
);

    localparam int IW = $clog2(CAPACITY);       // slot index width
    localparam int LW = $clog2(CAPACITY + 1);   // link width, holds the null marker
    localparam logic [LW-1:0] NULL_LINK = LW'(CAPACITY);
    localparam logic [IW-1:0] LAST_CNT  = IW'(CAPACITY - 1);

    t_state                r_state, n_state;
    logic [CAPACITY-1:0]   r_used, n_used;
    logic [LW-1:0]         r_head, n_head;
    logic [LW-1:0]         r_tail, n_tail;
    logic [LW-1:0]         r_cur, n_cur;     // walk pointer
    logic [IW-1:0]         r_cnt, n_cnt;     // elements emitted in this walk
    logic [IW-1:0]         r_pos, n_pos;     // slot appended, awaiting its null link

    // output register
    logic                  r_m_valid, n_m_valid;
    logic [31:0]           r_m_data, n_m_data;
    logic [1:0]            r_m_user, n_m_user;
    logic                  r_m_last, n_m_last;

    // slot memory ports
    logic                  data_we;
    logic [IW-1:0]         data_addr;
    logic [31:0]           data_wdata;
    logic                  next_we;
    logic [IW-1:0]         next_addr;
    logic [LW-1:0]         next_wdata;
    logic [31:0]           rd_data;
    logic [LW-1:0]         rd_next;

    logic                  free_found;
    logic [IW-1:0]         free_pos;
    logic                  head_null;
    logic                  head_live;
    logic                  out_free;
    logic                  accept;
    logic                  walk_end;

    alli_slots #(
        .CAPACITY (CAPACITY)
    ) u_slots (
        .i_clk        (i_clk),
        .i_data_we    (data_we),
        .i_data_addr  (data_addr),
        .i_data_wdata (data_wdata),
        .i_next_we    (next_we),
        .i_next_addr  (next_addr),
        .i_next_wdata (next_wdata),
        .i_rd_addr    (r_cur[IW-1:0]),
        .o_rd_data    (rd_data),
        .o_rd_next    (rd_next)
    );

    // lowest free slot: priority encoder over the used flags
    always_comb begin
        free_found = 1'b0;
        free_pos   = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_found = 1'b1;
                free_pos   = IW'(i);
            end
        end
    end

    assign head_null = (r_head >= NULL_LINK);
    assign head_live = !head_null && r_used[r_head[IW-1:0]];
    assign out_free  = !r_m_valid || m_tready;
    assign s_tready  = (r_state == S_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    // walk stops at a null link or after CAPACITY elements
    assign walk_end  = (rd_next >= NULL_LINK) || (r_cnt == LAST_CNT);

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;
    assign m_tuser  = r_m_user;
    assign m_tlast  = r_m_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_head    <= NULL_LINK;
            r_tail    <= NULL_LINK;
            r_cur     <= NULL_LINK;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_cur     <= n_cur;
            r_cnt     <= n_cnt;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
        r_m_last <= n_m_last;
    end

    always_comb begin
        n_state    = r_state;
        n_used     = r_used;
        n_head     = r_head;
        n_tail     = r_tail;
        n_cur      = r_cur;
        n_cnt      = r_cnt;
        n_pos      = r_pos;
        n_m_valid  = r_m_valid && !m_tready;
        n_m_data   = r_m_data;
        n_m_user   = r_m_user;
        n_m_last   = r_m_last;
        data_we    = 1'b0;
        data_addr  = free_pos;
        data_wdata = s_tdata;
        next_we    = 1'b0;
        next_addr  = free_pos;
        next_wdata = NULL_LINK;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (s_tuser)
                        OP_APPEND, OP_PREPEND: begin
                            n_m_valid = 1'b1;
                            n_m_data  = '0;
                            n_m_last  = 1'b1;
                            n_m_user  = ST_OK;
                            if (head_null) begin
                                // first element always lands in slot 0
                                data_we    = 1'b1;
                                data_addr  = '0;
                                next_we    = 1'b1;
                                next_addr  = '0;
                                next_wdata = NULL_LINK;
                                n_used[0]  = 1'b1;
                                n_head     = '0;
                                n_tail     = '0;
                            end else if (!free_found) begin
                                n_m_user = ST_FULL;
                            end else begin
                                data_we          = 1'b1;
                                n_used[free_pos] = 1'b1;
                                next_we          = 1'b1;
                                if (s_tuser == OP_APPEND) begin
                                    next_addr  = r_tail[IW-1:0];
                                    next_wdata = LW'(free_pos);
                                    n_tail     = LW'(free_pos);
                                    n_pos      = free_pos;
                                    n_state    = S_LINK;
                                end else begin
                                    next_addr  = free_pos;
                                    next_wdata = r_head;
                                    n_head     = LW'(free_pos);
                                end
                            end
                        end
                        OP_READ: begin
                            if (!head_live) begin
                                n_m_valid = 1'b1;
                                n_m_data  = '0;
                                n_m_user  = ST_EMPTY;
                                n_m_last  = 1'b1;
                            end else begin
                                n_cur   = r_head;
                                n_cnt   = '0;
                                n_state = S_WALK_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LINK: begin
                // new tail gets its null link
                next_we    = 1'b1;
                next_addr  = r_pos;
                next_wdata = NULL_LINK;
                n_state    = S_IDLE;
            end
            S_WALK_RD: begin
                // memory read of r_cur in flight
                n_state = S_WALK_EMIT;
            end
            S_WALK_EMIT: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_data  = rd_data;
                    n_m_user  = ST_OK;
                    n_m_last  = walk_end;
                    n_cur     = rd_next;
                    n_cnt     = r_cnt + IW'(1);
                    n_state   = walk_end ? S_IDLE : S_WALK_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // a live head always comes with a live tail
    a_head_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head < NULL_LINK) |-> (r_tail < NULL_LINK) && r_used[r_head[IW-1:0]])
        else $error("head set without tail");

    // the walk only ever visits real slots
    a_walk_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK_RD || r_state == S_WALK_EMIT) |-> (r_cur < NULL_LINK))
        else $error("walk pointer out of range");

    // slots are never released
    a_used_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ($countones(r_used) >= $past($countones(r_used))))
        else $error("used flag cleared");

    // insert into an empty list takes slot 0 as head and tail
    a_first_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && head_null && (s_tuser == OP_APPEND || s_tuser == OP_PREPEND))
        |=> (r_head == '0) && (r_tail == '0) && r_used[0])
        else $error("first insert not in slot 0");

    // the tail link stage follows only a successful append
    a_link_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK) |-> ($past(accept) && ($past(s_tuser) == OP_APPEND)
                                 && (r_tail == LW'(r_pos))))
        else $error("link stage without append");

endmodule

`default_nettype wire

// ===== sim/tb_array_linked_list_insert_top.sv =====
// Self-checking testbench for the array-backed linked list: inserts, full refusals, read-outs.
`timescale 1ns / 1ps

module tb_array_linked_list_insert_top;
    import alli_pkg::*;

    localparam int LIST_SLOTS      = 16;
    localparam int RANDOM_REQUESTS = 170;
    localparam int PRESSURE_ITEMS  = 16;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 80;
    // no kind of its own in the package; the block must drop it
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] value;
        logic        last;
    } t_list_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] new_value
    logic [1:0]  s_tuser;   // [1:0] opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] out_value
    logic [1:0]  m_tuser;   // [1:0] status
    logic        m_tlast;

    array_linked_list_insert_top #(
        .CAPACITY (LIST_SLOTS)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow copy of the list, advanced at every accepted request
    logic [31:0]  slot_value [LIST_SLOTS];
    int           slot_link  [LIST_SLOTS];
    bit           slot_taken [LIST_SLOTS] = '{default: 1'b0};
    int           head_slot = LIST_SLOTS;   // LIST_SLOTS acts as the null link
    int           tail_slot = LIST_SLOTS;
    t_list_result pending_list_results [$];

    // Run controls shared by the request and result sides
    bit no_idle      = 1'b0;   // both sides stop idling while set
    int hold_request = 0;      // long result-side hold, picked up by the sink

    int error_count     = 0;
    int requests_sent   = 0;
    int reads_sent      = 0;
    int results_checked = 0;
    int full_refusals   = 0;
    int empty_reports   = 0;

    function automatic int draw_wait();
        if (no_idle)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    // Lowest free slot, or slot 0 when the list is still empty
    function automatic logic [1:0] model_insert(logic [31:0] val, bit at_tail);
        int pos;
        int i;
        if (head_slot >= LIST_SLOTS) begin
            head_slot     = 0;
            tail_slot     = 0;
            slot_value[0] = val;
            slot_taken[0] = 1'b1;
            slot_link[0]  = LIST_SLOTS;
            return ST_OK;
        end
        pos = LIST_SLOTS;
        for (i = LIST_SLOTS - 1; i >= 0; i--)
            if (!slot_taken[i])
                pos = i;
        if (pos >= LIST_SLOTS)
            return ST_FULL;
        slot_value[pos] = val;
        slot_taken[pos] = 1'b1;
        if (at_tail) begin
            if (tail_slot < LIST_SLOTS)
                slot_link[tail_slot] = pos;
            tail_slot      = pos;
            slot_link[pos] = LIST_SLOTS;
        end else begin
            slot_link[pos] = head_slot;
            head_slot      = pos;
        end
        return ST_OK;
    endfunction

    function automatic void predict_list_op(logic [1:0] op, logic [31:0] val);
        int           walk;
        int           emitted;
        t_list_result r;
        case (op)
            OP_APPEND, OP_PREPEND: begin
                r = '{status: model_insert(val, op == OP_APPEND), value: '0, last: 1'b1};
                pending_list_results.push_back(r);
            end
            OP_READ: begin
                walk = head_slot;
                if (walk >= LIST_SLOTS || !slot_taken[walk]) begin
                    r = '{status: ST_EMPTY, value: '0, last: 1'b1};
                    pending_list_results.push_back(r);
                end else begin
                    emitted = 0;
                    // walk ends at a null link or after a full list's worth
                    while (walk < LIST_SLOTS && emitted < LIST_SLOTS) begin
                        r = '{status: ST_OK, value: slot_value[walk], last: 1'b0};
                        emitted++;
                        walk   = slot_link[walk];
                        r.last = !(walk < LIST_SLOTS && emitted < LIST_SLOTS);
                        pending_list_results.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        error_count++;
    endtask

    task automatic check_result(input t_list_result got);
        t_list_result want;
        if (pending_list_results.size() == 0) begin
            flag_mismatch($sformatf("unexpected result status=%0d value=%h last=%b",
                                    got.status, got.value, got.last));
            return;
        end
        want = pending_list_results.pop_front();
        results_checked++;
        if (got.status === ST_FULL)
            full_refusals++;
        if (got.status === ST_EMPTY)
            empty_reports++;
        if (got.status !== want.status)
            flag_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.value !== want.value)
            flag_mismatch($sformatf("value %h, expected %h", got.value, want.value));
        if (got.last !== want.last)
            flag_mismatch($sformatf("last %b, expected %b", got.last, want.last));
    endtask

    // Called at a falling edge; returns at the falling edge after the accept.
    // Valid is only dropped when a gap follows, so back-to-back requests keep it high.
    task automatic send_request(input logic [1:0] op, input logic [31:0] val);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= val;
        do
            @(posedge i_clk);
        while (!s_tready);
        predict_list_op(op, val);
        if (op != OP_UNUSED)
            requests_sent++;
        if (op == OP_READ)
            reads_sent++;
        @(negedge i_clk);
    endtask

    // Result side: check on each accepted result, then draw a fresh wait.
    // A long hold overrides the per-result waits.
    initial begin : result_sink
        t_list_result got;
        int           sink_wait;
        int           hold_left;
        sink_wait = 0;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_tvalid && m_tready) begin
                got = '{status: m_tuser, value: m_tdata, last: m_tlast};
                check_result(got);
                sink_wait = draw_wait();
            end
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (sink_wait > 0) begin
                sink_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Empty list: read gives one empty status, unused kind gives nothing
    task automatic test_empty_list();
        send_request(OP_READ, 32'h0000_0000);
        send_request(OP_UNUSED, 32'hFFFF_FFFF);
        send_request(OP_READ, 32'hFFFF_FFFF);
    endtask

    // First insert lands in slot 0; then both ends grow, with extreme values
    task automatic test_first_inserts();
        send_request(OP_APPEND, 32'h8000_0000);
        send_request(OP_READ, 32'h0000_0000);
        send_request(OP_PREPEND, 32'h7FFF_FFFF);
        send_request(OP_APPEND, 32'h0000_0000);
        send_request(OP_PREPEND, 32'hFFFF_FFFF);
        send_request(OP_UNUSED, 32'h1234_5678);
        send_request(OP_APPEND, 32'h0000_0001);
        send_request(OP_READ, 32'hFFFF_FFFF);
    endtask

    // Fill the remaining slots, then both insert kinds must be refused
    task automatic test_fill_to_full();
        int k;
        for (k = 0; k < 11; k++) begin
            if (k == 0)
                send_request(OP_APPEND, 32'hAAAA_AAAA);
            else if (k == 1)
                send_request(OP_PREPEND, 32'h5555_5555);
            else
                send_request(k[0] ? OP_PREPEND : OP_APPEND, $urandom());
        end
        send_request(OP_APPEND, 32'hDEAD_BEEF);
        send_request(OP_PREPEND, 32'h0F0F_0F0F);
        send_request(OP_READ, 32'h0000_0000);
    endtask

    // Hold off the result side while requests keep coming, so the block backs up
    task automatic test_backpressure();
        int k;
        no_idle      = 1'b1;
        hold_request = HOLD_CYCLES;
        send_request(OP_READ, $urandom());
        for (k = 1; k < PRESSURE_ITEMS; k++)
            send_request(k[1:0] == 2'd0 ? OP_APPEND : OP_READ, $urandom());
        no_idle = 1'b0;
    endtask

    // Mixed traffic; idling switched off in some stretches
    task automatic test_random_traffic();
        int         counted;
        int         pick;
        logic [1:0] op;
        counted = 0;
        while (counted < RANDOM_REQUESTS) begin
            if (counted % 30 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 40)
                op = OP_READ;
            else if (pick < 65)
                op = OP_APPEND;
            else if (pick < 90)
                op = OP_PREPEND;
            else
                op = OP_UNUSED;
            send_request(op, $urandom());
            if (op != OP_UNUSED)
                counted++;
        end
        no_idle = 1'b0;
    endtask

    initial begin : stimulus
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_APPEND;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_list();
        test_first_inserts();
        test_fill_to_full();
        test_backpressure();
        test_random_traffic();

        s_tvalid <= 1'b0;
        while (pending_list_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests (%0d read-outs), %0d results checked,",
                 requests_sent, reads_sent, results_checked);
        $display("  %0d full refusals, %0d empty-list reports, %0d mismatches.",
                 full_refusals, empty_reports, error_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Timeout: %0d results still outstanding", pending_list_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
